>>> sv/i2csr_pkg.sv
// Shared types, register map and reset constants for the I2C stuck-bus recovery block.
package i2csr_pkg;

  localparam int unsigned PULSE_COUNT_DEFAULT = 9;

  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;

  localparam logic [1:0] REG_INACTIVITY_LIMIT  = 2'd0;
  localparam logic [1:0] REG_COOLDOWN_TICKS    = 2'd1;
  localparam logic [1:0] REG_HALF_PERIOD_TICKS = 2'd2;

  localparam logic [31:0] INACTIVITY_LIMIT_RESET  = 32'd30000000;
  localparam logic [31:0] COOLDOWN_TICKS_RESET    = 32'd10000000;
  localparam logic [15:0] HALF_PERIOD_TICKS_RESET = 16'd5;

  typedef struct packed {
    logic [31:0] inactivity_limit;
    logic [31:0] cooldown_ticks;
    logic [15:0] half_period_ticks;
  } cfg_t;

  typedef struct packed {
    logic scl_drive_low;
    logic sda_drive_low;
    logic recovering;
    logic reinit_pulse;
  } result_t;

endpackage

>>> sv/i2csr_regs.sv
// APB register file holding the recovery limits and the half period.
module i2csr_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [i2csr_pkg::ADDR_W-1:0] paddr,
  input  logic [i2csr_pkg::DATA_W-1:0] pwdata,
  output logic [i2csr_pkg::DATA_W-1:0] prdata,
  output logic                         pready,
  output i2csr_pkg::cfg_t              cfg
);
  import i2csr_pkg::*;

  logic       wr_en;
  logic [1:0] reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.inactivity_limit  <= INACTIVITY_LIMIT_RESET;
      cfg.cooldown_ticks    <= COOLDOWN_TICKS_RESET;
      cfg.half_period_ticks <= HALF_PERIOD_TICKS_RESET;
    end else if (wr_en) begin
      case (reg_sel)
        REG_INACTIVITY_LIMIT:  cfg.inactivity_limit  <= pwdata;
        REG_COOLDOWN_TICKS:    cfg.cooldown_ticks    <= pwdata;
        REG_HALF_PERIOD_TICKS: cfg.half_period_ticks <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_INACTIVITY_LIMIT:  prdata = cfg.inactivity_limit;
      REG_COOLDOWN_TICKS:    prdata = cfg.cooldown_ticks;
      REG_HALF_PERIOD_TICKS: prdata = {16'd0, cfg.half_period_ticks};
      default:               prdata = '0;
    endcase
  end

endmodule

>>> sv/i2csr_seq.sv
// Tick counters and recovery sequencer; one item advances the state by one tick.
module i2csr_seq #(
  parameter int unsigned PULSE_COUNT = i2csr_pkg::PULSE_COUNT_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  i2csr_pkg::cfg_t    cfg,
  input  logic               accept,
  input  logic               activity,
  input  logic               sda_level,
  output i2csr_pkg::result_t res
);
  import i2csr_pkg::*;

  localparam int unsigned PCW = (2 * PULSE_COUNT > 1) ? $clog2(2 * PULSE_COUNT) : 1;
  localparam logic [PCW-1:0] PULSE_LAST = PCW'(2 * PULSE_COUNT - 1);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_CHECK  = 5'b00010,
    ST_PULSE  = 5'b00100,
    ST_STOP   = 5'b01000,
    ST_REINIT = 5'b10000
  } state_t;

  state_t      state, state_next;
  logic [31:0] idle_ticks, idle_ticks_next;
  logic [31:0] since_recovery, since_recovery_next;
  logic [15:0] half_count, half_count_next;
  logic [PCW-1:0] pulse_idx, pulse_idx_next;

  logic [31:0] since_inc;
  logic [15:0] half_len;
  logic [16:0] half_cnt_inc;
  logic        half_done;

  assign since_inc    = (since_recovery == '1) ? since_recovery : since_recovery + 32'd1;
  assign half_len     = (cfg.half_period_ticks == '0) ? 16'd1 : cfg.half_period_ticks;
  assign half_cnt_inc = {1'b0, half_count} + 17'd1;
  assign half_done    = half_cnt_inc >= {1'b0, half_len};

  always_comb begin
    idle_ticks_next     = activity ? '0 :
                          ((idle_ticks == '1) ? idle_ticks : idle_ticks + 32'd1);
    since_recovery_next = since_inc;
    state_next          = state;
    half_count_next     = half_count;
    pulse_idx_next      = pulse_idx;
    res                 = '0;
    case (state)
      ST_IDLE: begin
        if (idle_ticks_next > cfg.inactivity_limit && since_inc >= cfg.cooldown_ticks) begin
          state_next      = ST_CHECK;
          half_count_next = '0;
        end
      end
      ST_CHECK: begin
        res.recovering = 1'b1;
        if (half_done) begin
          half_count_next = '0;
          if (!sda_level) begin
            state_next          = ST_PULSE;
            pulse_idx_next      = '0;
            since_recovery_next = '0;
          end else begin
            state_next = ST_IDLE;
          end
        end else begin
          half_count_next = half_cnt_inc[15:0];
        end
      end
      ST_PULSE: begin
        res.recovering    = 1'b1;
        // even half periods hold SCL low
        res.scl_drive_low = ~pulse_idx[0];
        if (half_done) begin
          half_count_next = '0;
          if (pulse_idx == PULSE_LAST) begin
            state_next = ST_STOP;
          end else begin
            pulse_idx_next = pulse_idx + PCW'(1);
          end
        end else begin
          half_count_next = half_cnt_inc[15:0];
        end
      end
      ST_STOP: begin
        res.recovering    = 1'b1;
        res.sda_drive_low = 1'b1;
        if (half_done) begin
          half_count_next = '0;
          state_next      = ST_REINIT;
        end else begin
          half_count_next = half_cnt_inc[15:0];
        end
      end
      ST_REINIT: begin
        res.recovering   = 1'b1;
        res.reinit_pulse = 1'b1;
        state_next       = ST_IDLE;
        half_count_next  = '0;
      end
      default: begin
        state_next      = ST_IDLE;
        half_count_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      idle_ticks     <= '0;
      since_recovery <= '0;
      half_count     <= '0;
      pulse_idx      <= '0;
    end else if (accept) begin
      state          <= state_next;
      idle_ticks     <= idle_ticks_next;
      since_recovery <= since_recovery_next;
      half_count     <= half_count_next;
      pulse_idx      <= pulse_idx_next;
    end
  end

`ifndef SYNTHESIS
  a_reinit_to_idle: assert property (@(posedge clk) disable iff (rst)
    (accept && state == ST_REINIT) |=> (state == ST_IDLE && half_count == '0))
    else $error("sequencer did not return to idle after reinit");

  a_start_clears_cooldown: assert property (@(posedge clk) disable iff (rst)
    (accept && state == ST_CHECK && half_done && !sda_level)
      |=> (state == ST_PULSE && since_recovery == '0 && pulse_idx == '0))
    else $error("recovery start did not clear cooldown count");

  a_pulse_idx_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PULSE) |-> (pulse_idx <= PULSE_LAST))
    else $error("pulse index out of range");
`endif

endmodule

>>> sv/i2csr_outbuf.sv
// Result register with a skid entry so an item is taken while a result waits.
module i2csr_outbuf (
  input  logic               clk,
  input  logic               rst,
  input  logic               tick_valid,
  output logic               tick_stall,
  output logic               accept,
  input  i2csr_pkg::result_t res_in,
  output logic               result_valid,
  input  logic               result_stall,
  output i2csr_pkg::result_t res_out
);
  import i2csr_pkg::*;

  result_t skid;
  logic    skid_valid;
  logic    drain;

  assign tick_stall = skid_valid;
  assign accept     = tick_valid && !tick_stall;
  assign drain      = result_valid && !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (skid_valid) begin
      if (drain) begin
        skid_valid <= 1'b0;
      end
    end else if (accept) begin
      if (!result_valid || drain) begin
        result_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (drain) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (drain) begin
        res_out <= skid;
      end
    end else if (accept) begin
      if (!result_valid || drain) begin
        res_out <= res_in;
      end else begin
        skid <= res_in;
      end
    end
  end

endmodule

>>> sv/i2c_stuck_bus_recovery.sv
// I2C stuck-bus recovery: idle watchdog, SDA check and a bus clear of PULSE_COUNT SCL pulses.
// The result of an accepted tick item is registered in the output register, or in the skid entry while a result waits.
// Throughput: one item per cycle while tick_stall is low; the sequencer state register feeds its own next-state logic.
// A two-entry result buffer (output register plus skid) decouples the two channel stalls.
// Reset (synchronous, rst high): counters and half count cleared, sequencer idle,
// result buffer empty, registers back to their reset limits.
module i2c_stuck_bus_recovery #(
  parameter int unsigned PULSE_COUNT = i2csr_pkg::PULSE_COUNT_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [i2csr_pkg::ADDR_W-1:0] paddr,
  input  logic [i2csr_pkg::DATA_W-1:0] pwdata,
  output logic [i2csr_pkg::DATA_W-1:0] prdata,
  output logic                         pready,
  input  logic                         tick_valid,
  output logic                         tick_stall,
  input  logic                         activity,
  input  logic                         sda_level,
  output logic                         result_valid,
  input  logic                         result_stall,
  output logic                         scl_drive_low,
  output logic                         sda_drive_low,
  output logic                         recovering,
  output logic                         reinit_pulse
);
  import i2csr_pkg::*;

  cfg_t    cfg;
  result_t res_now;
  result_t res_held;
  logic    accept;

  i2csr_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  i2csr_seq #(
    .PULSE_COUNT (PULSE_COUNT)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .accept    (accept),
    .activity  (activity),
    .sda_level (sda_level),
    .res       (res_now)
  );

  i2csr_outbuf u_outbuf (
    .clk          (clk),
    .rst          (rst),
    .tick_valid   (tick_valid),
    .tick_stall   (tick_stall),
    .accept       (accept),
    .res_in       (res_now),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .res_out      (res_held)
  );

  assign scl_drive_low = res_held.scl_drive_low;
  assign sda_drive_low = res_held.sda_drive_low;
  assign recovering    = res_held.recovering;
  assign reinit_pulse  = res_held.reinit_pulse;

endmodule

>>> dv/testbench.sv
// Self-checking testbench for the I2C stuck-bus recovery block: directed and random ticks.
module testbench;
  import i2csr_pkg::*;

  localparam int unsigned PULSES = PULSE_COUNT_DEFAULT;
  localparam int unsigned PH_IDLE = 0;
  localparam int unsigned PH_CHECK = 1;
  localparam int unsigned PH_PULSE0 = 2;
  localparam int unsigned PH_STOP = PH_PULSE0 + 2 * PULSES;
  localparam int unsigned PH_REINIT = PH_STOP + 1;
  localparam int unsigned LONG_HOLD = 48;
  localparam int unsigned CYCLE_LIMIT = 300000;

  logic clk = 1'b0;
  logic rst;
  logic psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;
  logic tick_valid, tick_stall;
  logic activity, sda_level;
  logic result_valid, result_stall;
  logic scl_drive_low, sda_drive_low, recovering, reinit_pulse;

  i2c_stuck_bus_recovery uut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .tick_valid(tick_valid), .tick_stall(tick_stall),
    .activity(activity), .sda_level(sda_level),
    .result_valid(result_valid), .result_stall(result_stall),
    .scl_drive_low(scl_drive_low), .sda_drive_low(sda_drive_low),
    .recovering(recovering), .reinit_pulse(reinit_pulse)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog state mirrored from the block
  cfg_t model_cfg;
  logic [31:0] idle_cnt;
  logic [31:0] since_rec;
  int unsigned seq_phase;
  logic [15:0] half_cnt;

  result_t due_outputs[$];
  int err_count = 0;
  int ticks_taken = 0;
  int results_seen = 0;
  int bus_clears = 0;
  int reg_writes = 0;
  int cycle_count = 0;
  bit gaps_on = 1'b1;
  bit hold_long = 1'b0;

  function automatic logic [31:0] bump(logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  // Count one tick of the current phase; true when the phase is over.
  function automatic bit half_done();
    logic [16:0] hp, n;
    hp = (model_cfg.half_period_ticks == 16'd0) ? 17'd1 : {1'b0, model_cfg.half_period_ticks};
    n = {1'b0, half_cnt} + 17'd1;
    if (n >= hp) begin
      half_cnt = '0;
      return 1'b1;
    end
    half_cnt = n[15:0];
    return 1'b0;
  endfunction

  function automatic result_t step_bus_watchdog(logic act, logic sda);
    result_t r;
    int unsigned ph;
    r = '0;
    ph = seq_phase;
    idle_cnt = act ? 32'd0 : bump(idle_cnt);
    since_rec = bump(since_rec);
    if (ph == PH_IDLE) begin
      if (idle_cnt > model_cfg.inactivity_limit && since_rec >= model_cfg.cooldown_ticks) begin
        seq_phase = PH_CHECK;
        half_cnt = '0;
      end
    end else if (ph == PH_CHECK) begin
      r.recovering = 1'b1;
      if (half_done()) begin
        if (!sda) begin
          seq_phase = PH_PULSE0;
          since_rec = '0;
        end else begin
          seq_phase = PH_IDLE;
        end
      end
    end else if (ph < PH_STOP) begin
      r.recovering = 1'b1;
      r.scl_drive_low = ((ph - PH_PULSE0) % 2) == 0;
      if (half_done()) seq_phase = ph + 1;
    end else if (ph == PH_STOP) begin
      r.recovering = 1'b1;
      r.sda_drive_low = 1'b1;
      if (half_done()) seq_phase = PH_REINIT;
    end else begin
      r.recovering = 1'b1;
      r.reinit_pulse = 1'b1;
      seq_phase = PH_IDLE;
      half_cnt = '0;
    end
    return r;
  endfunction

  task automatic check_line(string name, logic want, logic got);
    if (got !== want) begin
      $error("%s: expected %0b, got %0b", name, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk) begin : monitor
    result_t want;
    if (!rst) begin
      if (tick_valid && !tick_stall) begin
        due_outputs.push_back(step_bus_watchdog(activity, sda_level));
        ticks_taken++;
      end
      if (result_valid && !result_stall) begin
        results_seen++;
        if (reinit_pulse === 1'b1) bus_clears++;
        if (due_outputs.size() == 0) begin
          $error("result with no tick waiting for it");
          err_count++;
        end else begin
          want = due_outputs.pop_front();
          check_line("scl_drive_low", want.scl_drive_low, scl_drive_low);
          check_line("sda_drive_low", want.sda_drive_low, sda_drive_low);
          check_line("recovering", want.recovering, recovering);
          check_line("reinit_pulse", want.reinit_pulse, reinit_pulse);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               due_outputs.size());
      $display("simulation failed");
      $finish;
    end
  end

  // Result side: random stall bursts, plus one long hold on request
  initial begin : result_pacing
    result_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_long) begin
        hold_long = 1'b0;
        result_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        result_stall <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 9) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_INACTIVITY_LIMIT: model_cfg.inactivity_limit = val;
      REG_COOLDOWN_TICKS: model_cfg.cooldown_ticks = val;
      REG_HALF_PERIOD_TICKS: model_cfg.half_period_ticks = val[15:0];
      default: ;
    endcase
    reg_writes++;
    @(posedge clk);
  endtask

  task automatic set_watchdog(input logic [31:0] limit, input logic [31:0] cool,
                              input logic [31:0] half);
    reg_write(REG_INACTIVITY_LIMIT, limit);
    reg_write(REG_COOLDOWN_TICKS, cool);
    reg_write(REG_HALF_PERIOD_TICKS, half);
  endtask

  task automatic send_tick(input logic act, input logic sda);
    if (gaps_on && $urandom_range(0, 7) == 0) begin
      tick_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    tick_valid <= 1'b1;
    activity <= act;
    sda_level <= sda;
    do @(posedge clk); while (tick_stall);
  endtask

  // Drop valid and wait until every tick has produced its result
  task automatic wait_quiet();
    tick_valid <= 1'b0;
    do @(posedge clk); while (due_outputs.size() != 0);
  endtask

  task automatic test_default_config();
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    wait_quiet();
  endtask

  // Zero limit and zero half period: not-stuck check, then a full bus clear
  task automatic test_zero_settings();
    set_watchdog(32'd0, 32'd0, 32'd0);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b0);
    // activity mid-sequence must not abort it
    for (int i = 0; i < 2 * PULSES + 2; i++) send_tick(i % 3 == 1, i % 2 == 0);
    wait_quiet();
  endtask

  task automatic test_extreme_settings();
    set_watchdog(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    wait_quiet();
    // enter a check with the longest half period, then shorten it mid-check
    set_watchdog(32'd1, 32'd0, 32'h0000_FFFF);
    for (int i = 0; i < 5; i++) send_tick(1'b0, 1'b1);
    wait_quiet();
    reg_write(REG_HALF_PERIOD_TICKS, 32'd1);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b1);
    wait_quiet();
  endtask

  task automatic test_random_traffic(input int phases, input int per_phase);
    int odds;
    logic [15:0] half;
    for (int p = 0; p < phases; p++) begin
      wait_quiet();
      half = ($urandom_range(0, 5) == 0) ? 16'($urandom_range(4, 8)) :
                                           16'($urandom_range(0, 3));
      set_watchdog($urandom_range(0, 10), $urandom_range(0, 60), {16'($urandom), half});
      // mostly long idle stretches; one phase of busy noise
      odds = (p == 2) ? 2 : 24;
      for (int i = 0; i < per_phase; i++)
        send_tick($urandom_range(0, odds - 1) == 0, $urandom_range(0, 2) == 0);
    end
    wait_quiet();
  endtask

  task automatic test_backpressure();
    gaps_on = 1'b0;
    set_watchdog(32'd2, 32'd5, 32'd1);
    hold_long = 1'b1;
    for (int i = 0; i < 50; i++) send_tick($urandom_range(0, 15) == 0, $urandom_range(0, 1));
    wait_quiet();
    gaps_on = 1'b1;
  endtask

  task automatic test_no_gaps();
    gaps_on = 1'b0;
    set_watchdog($urandom_range(1, 4), $urandom_range(0, 20), $urandom_range(1, 2));
    for (int i = 0; i < 80; i++) send_tick($urandom_range(0, 19) == 0, $urandom_range(0, 1));
    wait_quiet();
  endtask

  initial begin
    model_cfg.inactivity_limit = INACTIVITY_LIMIT_RESET;
    model_cfg.cooldown_ticks = COOLDOWN_TICKS_RESET;
    model_cfg.half_period_ticks = HALF_PERIOD_TICKS_RESET;
    idle_cnt = '0;
    since_rec = '0;
    seq_phase = PH_IDLE;
    half_cnt = '0;
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    tick_valid <= 1'b0;
    activity <= 1'b0;
    sda_level <= 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_default_config();
    test_zero_settings();
    test_extreme_settings();
    test_random_traffic(6, 90);
    test_backpressure();
    test_no_gaps();

    repeat (8) @(posedge clk);
    $display("ran %0d ticks across %0d register writes; %0d results checked",
             ticks_taken, reg_writes, results_seen);
    $display("%0d complete bus clear sequences observed, %0d mismatches", bus_clears, err_count);
    if (err_count == 0 && due_outputs.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
